// File: src/rational_add_mul_reduce_assert.svh
// assertion macros for the rational arithmetic block
`ifndef RATIONAL_ADD_MUL_REDUCE_ASSERT_SVH
`define RATIONAL_ADD_MUL_REDUCE_ASSERT_SVH
`ifndef SYNTHESIS
`define RAMR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define RAMR_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RAMR_ASSERT(label, clk, rst, prop)
`define RAMR_ASSERT_NORST(label, clk, prop)
`endif
`endif

// File: src/ramr_pkg.sv
// package: types, codes and constants of the rational arithmetic block
package ramr_pkg;
  localparam int FieldWidth = 16;
  localparam int NumW = 32;
  localparam int DenW = 30;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_CMP = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [FieldWidth-1:0] a_num;
    logic [FieldWidth-2:0] a_den;
    logic [FieldWidth-1:0] b_num;
    logic [FieldWidth-2:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [29:0] res_den;
    logic        is_equal;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_COMB, S_GCD, S_DIVN, S_DIVD, S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic comb;
    logic gcd_step;
    logic div_start;
    logic div_sel_den;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic direct;
    logic gcd_done;
    logic div_done;
  } dp_sts_t;
endpackage

// File: src/ramr_ctrl.sv
// controller state machine of the rational arithmetic block
module ramr_ctrl import ramr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy
);
  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_next = S_COMB;
      end
      S_COMB: begin
        cmd.comb = 1'b1;
        state_next = sts.direct ? S_DONE : S_GCD;
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_start = 1'b1;
          state_next = S_DIVN;
        end else cmd.gcd_step = 1'b1;
      end
      S_DIVN: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel_den = 1'b1;
          state_next = S_DIVD;
        end else cmd.div_step = 1'b1;
      end
      S_DIVD: begin
        cmd.div_sel_den = 1'b1;
        if (sts.div_done) state_next = S_DONE;
        else cmd.div_step = 1'b1;
      end
      S_DONE: begin
        cmd.emit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// File: src/ramr_dpath.sv
// datapath: products, signed combine, binary gcd and restoring divider
module ramr_dpath import ramr_pkg::*; (
  input  logic      clk,
  input  in_item_t  item,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output out_item_t result,
  output logic      done
);
  localparam int FW = FieldWidth;
  localparam int PW = 2 * FW;
  localparam int MW = 2 * FW + 1;
  localparam int CW = $clog2(MW + 1);

  logic [1:0]    op;
  logic [FW-1:0] ma, mb;
  logic [FW-2:0] ad, bd;
  logic          sa, sb, eq;
  logic [MW-1:0] p1, p2, den, mag;
  logic          sr;
  logic [MW-1:0] gx, gy;
  logic [CW-1:0] shift;
  logic [MW-1:0] gval;
  logic [MW-1:0] dq, drem, qn;
  logic [CW-1:0] dcnt;
  logic [FW-1:0] raw_a, raw_b;

  function automatic logic [MW-1:0] gdiff_c(input logic [MW-1:0] x, input logic [MW-1:0] y);
    gdiff_c = (x >= y) ? x - y : y - x;
  endfunction

  assign raw_a = FW'(item.a_num);
  assign raw_b = FW'(item.b_num);

  // gcd step values
  logic [MW-1:0] gdiff;
  assign gdiff = (gx >= gy) ? gx - gy : gy - gx;

  // divider step
  logic [MW:0] trial;
  assign trial = {drem, dq[MW-1]} - {1'b0, gval};

  always_ff @(posedge clk) begin
    // operand capture
    if (cmd.load) begin
      op <= item.opcode;
      sa <= raw_a[FW-1];
      sb <= raw_b[FW-1];
      ma <= raw_a[FW-1] ? (~raw_a + 1'b1) : raw_a;
      mb <= raw_b[FW-1] ? (~raw_b + 1'b1) : raw_b;
      ad <= (FW-1)'(item.a_den);
      bd <= (FW-1)'(item.b_den);
      eq <= (raw_a == raw_b) && (item.a_den == item.b_den);
    end
    // products: p1 and den in the first multiply step, p2 in the second
    if (cmd.mul1) begin
      p1 <= MW'(PW'(ma) * PW'(bd));
      den <= MW'(PW'(ad) * PW'(bd));
    end
    if (cmd.mul2) begin
      if (op == OP_MUL) p2 <= MW'(PW'(ma) * PW'(mb));
      else p2 <= MW'(PW'(mb) * PW'(ad));
    end
    // combine signs into magnitude
    if (cmd.comb) begin
      if (op == OP_MUL) begin
        mag <= p2; sr <= sa ^ sb;
      end else if (sa == sb) begin
        mag <= p1 + p2; sr <= sa;
      end else if (p1 >= p2) begin
        mag <= p1 - p2; sr <= sa;
      end else begin
        mag <= p2 - p1; sr <= sb;
      end
      gx <= (op == OP_MUL) ? p2 : ((sa == sb) ? p1 + p2 : gdiff_c(p1, p2));
      gy <= den;
      shift <= '0;
    end
    // binary gcd, one step per cycle
    if (cmd.gcd_step) begin
      if (gx == '0) begin
        gx <= gy;
      end else if (gy == '0) begin
        gy <= gy;
      end else if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1; gy <= gy >> 1; shift <= shift + 1'b1;
      end else if (!gx[0]) gx <= gx >> 1;
      else if (!gy[0]) gy <= gy >> 1;
      else begin
        gx <= (gx < gy) ? gx : gy;
        gy <= gdiff >> 1;
      end
    end
    if (cmd.div_start && !cmd.div_sel_den) gval <= (gy == '0 ? gx : (gx == '0 ? gy : gx)) << shift;
    // restoring divider, one quotient bit per cycle
    if (cmd.div_start) begin
      if (cmd.div_sel_den) qn <= dq;
      dq <= cmd.div_sel_den ? den : mag;
      drem <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      if (!trial[MW]) drem <= trial[MW-1:0];
      else drem <= {drem[MW-2:0], dq[MW-1]};
      dq <= {dq[MW-2:0], ~trial[MW]};
      dcnt <= dcnt + 1'b1;
    end
  end

  // status
  assign sts.direct = (op == OP_CMP) || (op == OP_NOP);
  assign sts.gcd_done = (gx == '0) || (gy == '0);
  assign sts.div_done = (dcnt == CW'(MW)) || (gval == '0);

  // result formation
  logic [MW-1:0] fnum, fden;
  always_comb begin
    fnum = (gval == '0) ? mag : qn;
    fden = (gval == '0) ? den : dq;
    result = '0;
    if (op == OP_CMP) result.is_equal = eq;
    else if (op != OP_NOP) begin
      result.res_num = (sr && fnum != '0) ? NumW'(~fnum + 1'b1) : NumW'(fnum);
      result.res_den = DenW'(fden);
    end
  end
  assign done = cmd.emit;
endmodule

// File: src/rational_add_mul_reduce.sv
// top level of the rational arithmetic block
//
// usage: drive in with opcode and two fractions and raise start while busy
// is low; the transaction is taken at that edge and busy rises.
// add and multiply form the exact result in sign-magnitude, reduce it by a
// binary gcd (one step a cycle) and then divide numerator and denominator
// by the gcd in a restoring divider, one quotient bit a cycle; compare and
// the unused opcode skip the gcd and the divider; one item at a time.
// busy is low again in the valid cycle, so the next transaction can be
// taken at the edge that ends it.
// the result appears on out for one cycle with valid high; the receiver
// cannot stall, so it must take the transaction in that cycle.
// reset returns the controller to idle and drops the transaction in flight.
module rational_add_mul_reduce import ramr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  in,
  output logic      busy,
  output logic      valid,
  output out_item_t out
);
`include "rational_add_mul_reduce_assert.svh"
  dp_cmd_t   cmd;
  dp_sts_t   sts;
  out_item_t res;
  logic      done;

  ramr_ctrl u_ctrl (.clk, .rst, .start, .sts, .cmd, .busy);
  ramr_dpath u_dpath (
    .clk, .item(in), .cmd, .sts, .result(res), .done
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else valid <= done;
    if (done) out <= res;
  end

  `RAMR_ASSERT(a_valid_busy, clk, rst, valid |-> !$past(valid))
  `RAMR_ASSERT(a_start_busy, clk, rst, (start && !busy) |=> busy)
  `RAMR_ASSERT(a_cmp_zero, clk, rst, (valid && out.is_equal) |-> (out.res_den == '0))
endmodule
